// ----- hdl/dithered_span_texture_draw_top_assert.svh -----
// Assertion macros shared by the span drawer.
`ifndef DITHERED_SPAN_TEXTURE_DRAW_TOP_ASSERT_SVH
`define DITHERED_SPAN_TEXTURE_DRAW_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define DSTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("span drawer check failed");

// check cons in the cycle after ante
`define DSTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("span drawer check failed");

`endif

// ----- hdl/dstd_pkg.sv -----
// Types, constants and the dither lookup of the span drawer.
package dstd_pkg;

    localparam logic [4:0] MAX_SHADE = 5'd17;
    localparam int         FRAC_BITS = 12;

    localparam logic [15:0] DITHER_ROWS [18] = '{
        16'h0000, 16'h0000, 16'h8000, 16'h8020, 16'h80A0, 16'hA0A0,
        16'hA0A1, 16'hA4A1, 16'hA4A5, 16'hA5A5, 16'hD5A5, 16'hD5E5,
        16'hD5F5, 16'hF5F5, 16'hF5FD, 16'hF7FD, 16'hF7FF, 16'hFFFF
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [7:0]         texel_value;
        logic [11:0]        texel_index;
        logic signed [31:0] v_step;
        logic signed [31:0] u_step;
        logic signed [31:0] v_frac;
        logic signed [31:0] u_frac;
        logic [7:0]         row;
        logic [8:0]         x_end;
        logic [8:0]         x_start;
    } t_in_item;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
    } t_ctrl_cmd;

    typedef struct packed {
        logic span_go;
        logic walk_last;
        logic stall;
        logic pix_valid;
    } t_ctrl_stat;

    function automatic logic dither_bit(input logic [4:0] shade, input logic [1:0] phase,
                                        input logic [1:0] xlo);
        logic [4:0]  s;
        logic [15:0] w;
        logic [3:0]  nib;
        s   = (shade > MAX_SHADE) ? MAX_SHADE : shade;
        w   = DITHER_ROWS[s];
        nib = w[{~phase, 2'b00} +: 4];
        return nib[~xlo];
    endfunction

endpackage

// ----- hdl/dithered_span_texture_draw_top.sv -----
// Top level of the dithered affine texture span drawer.
//
//  channel | dir | tdata fields, lowest bit up                          | tuser  | tlast
//  s       | in  | x_start, x_end, row, u_frac, v_frac, u_step, v_step, | action | -
//          |     | texel_index, texel_value                             |        |
//  m       | out | byte_address, write_mask, write_data                 | -      | last_write
//
//  A load beat writes the texture memory as it is accepted.
//  A draw beat walks x_start up to the clamped x_end, one texel fetch per cycle
//  while the output does not stall, through the single read port of the texture
//  memory, and then drains. An empty span is accepted and draws nothing. The walk
//  stalls while the output register stays full and untaken and a byte is due.
//  Reset clears control only; texture contents are undefined until loaded.
module dithered_span_texture_draw_top #(
    parameter int ROW_BYTES = 52,
    parameter int TEX_SIDE  = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // x_start, x_end, row, u_frac, v_frac, u_step, v_step, texel_index, texel_value
    input  logic [175:0] i_s_tdata,
    // action
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // byte_address, write_mask, write_data
    output logic [31:0]  o_m_tdata,
    output logic         o_m_tlast
);

    `include "dithered_span_texture_draw_top_assert.svh"

    dstd_pkg::t_in_item   item;
    dstd_pkg::t_ctrl_cmd  cmd;
    dstd_pkg::t_ctrl_stat stat;

    assign item = i_s_tdata[173:0];

    dstd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    dstd_datapath #(
        .ROW_BYTES (ROW_BYTES),
        .TEX_SIDE  (TEX_SIDE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    `DSTD_ASSERT_NOW(a_ready_pipe_empty, i_clk, i_rst_n, o_s_tready, !stat.pix_valid)
    `DSTD_ASSERT_NOW(a_no_issue_in_stall, i_clk, i_rst_n, cmd.issue, !stat.stall)
    `DSTD_ASSERT_NEXT(a_start_clean, i_clk, i_rst_n, cmd.start, !stat.pix_valid && !o_s_tready)

endmodule

// ----- hdl/dstd_ctrl.sv -----
// Controller state machine of the span drawer.
module dstd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_action,
    input  dstd_pkg::t_ctrl_stat  i_stat,
    output logic                  o_s_tready,
    output dstd_pkg::t_ctrl_cmd   o_cmd
);

    dstd_pkg::t_state r_state;
    dstd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dstd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            dstd_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.load  = i_s_tvalid && !i_action;
                o_cmd.start = i_s_tvalid && i_action && i_stat.span_go;
                if (o_cmd.start) begin
                    n_state = dstd_pkg::ST_WALK;
                end
            end
            dstd_pkg::ST_WALK: begin
                o_cmd.issue = !i_stat.stall;
                if (o_cmd.issue && i_stat.walk_last) begin
                    n_state = dstd_pkg::ST_DRAIN;
                end
            end
            dstd_pkg::ST_DRAIN: begin
                if (!i_stat.stall) begin
                    n_state = dstd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dstd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/dstd_datapath.sv -----
// Datapath of the span drawer: texture memory, uv walk, dither and byte gather.
module dstd_datapath #(
    parameter int ROW_BYTES = 52,
    parameter int TEX_SIDE  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dstd_pkg::t_in_item    i_item,
    input  dstd_pkg::t_ctrl_cmd   i_cmd,
    output dstd_pkg::t_ctrl_stat  o_stat,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [31:0]           o_m_tdata,
    output logic                  o_m_tlast
);

    localparam int TW    = $clog2(TEX_SIDE);
    localparam int AW    = 2 * TW;
    localparam int DEPTH = TEX_SIDE * TEX_SIDE;
    localparam int LIMIT = ROW_BYTES * 8;

    logic [4:0]  r_tex [DEPTH];
    logic [4:0]  r_rd;

    logic [31:0] idx_wide;
    logic        wr_ok;
    logic [AW-1:0] wr_addr;
    logic [4:0]  wr_val;
    logic [AW-1:0] rd_addr;
    logic [8:0]  eff_end;

    logic [8:0]  r_x;
    logic [8:0]  r_x_end;
    logic [31:0] r_u;
    logic [31:0] r_v;
    logic [31:0] r_du;
    logic [31:0] r_dv;
    logic [15:0] r_row_base;
    logic [1:0]  r_phase;
    logic [9:0]  x_next;

    logic        r_v1;
    logic [8:0]  r_x1;
    logic        r_last1;
    logic [7:0]  r_mask;
    logic [7:0]  r_data;
    logic        emit1;
    logic        stall;
    logic [7:0]  pos;
    logic [7:0]  new_mask;
    logic [7:0]  new_data;
    logic [16:0] addr_sum;

    logic        r_out_valid;
    logic [13:0] r_out_addr;
    logic [7:0]  r_out_mask;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    assign idx_wide = 32'(i_item.texel_index);
    assign wr_ok    = idx_wide < 32'(DEPTH);
    assign wr_addr  = idx_wide[AW-1:0];
    assign wr_val   = (i_item.texel_value > 8'(dstd_pkg::MAX_SHADE)) ?
                      dstd_pkg::MAX_SHADE : i_item.texel_value[4:0];
    assign rd_addr  = {r_v[dstd_pkg::FRAC_BITS +: TW], r_u[dstd_pkg::FRAC_BITS +: TW]};
    assign eff_end  = (32'(i_item.x_end) > 32'(LIMIT)) ? 9'(LIMIT) : i_item.x_end;
    assign x_next   = 10'(r_x) + 10'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_tex[wr_addr] <= wr_val;
        end
        if (i_cmd.issue) begin
            r_rd <= r_tex[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x        <= i_item.x_start;
            r_x_end    <= eff_end;
            r_u        <= i_item.u_frac;
            r_v        <= i_item.v_frac;
            r_du       <= i_item.u_step;
            r_dv       <= i_item.v_step;
            r_row_base <= 16'(32'(i_item.row) * ROW_BYTES);
            r_phase    <= i_item.row[1:0];
        end else if (i_cmd.issue) begin
            r_x <= x_next[8:0];
            r_u <= r_u + r_du;
            r_v <= r_v + r_dv;
        end
    end

    assign emit1    = (r_x1[2:0] == 3'b111) || r_last1;
    assign stall    = r_v1 && emit1 && r_out_valid && !i_m_tready;
    assign pos      = 8'h80 >> r_x1[2:0];
    assign new_mask = r_mask | pos;
    assign new_data = dstd_pkg::dither_bit(r_rd, r_phase, r_x1[1:0]) ? (r_data | pos) : r_data;
    assign addr_sum = 17'(r_row_base) + 17'(r_x1[8:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (!stall) begin
            r_v1 <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_x1    <= r_x;
            r_last1 <= (x_next == 10'(r_x_end));
        end
        if (i_cmd.start) begin
            r_mask <= '0;
            r_data <= '0;
        end else if (r_v1 && !stall) begin
            if (emit1) begin
                r_mask <= '0;
                r_data <= '0;
            end else begin
                r_mask <= new_mask;
                r_data <= new_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_v1 && emit1 && !stall) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && emit1 && !stall) begin
            r_out_addr <= addr_sum[13:0];
            r_out_mask <= new_mask;
            r_out_data <= new_data;
            r_out_last <= r_last1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data, r_out_mask, r_out_addr};
    assign o_m_tlast  = r_out_last;

    assign o_stat.span_go   = eff_end > i_item.x_start;
    assign o_stat.walk_last = (x_next == 10'(r_x_end));
    assign o_stat.stall     = stall;
    assign o_stat.pix_valid = r_v1;

endmodule

// ----- tb/dithered_span_texture_draw_top_tb.sv -----
// Self-checking testbench for the dithered texture span drawer, directed then random.
module dithered_span_texture_draw_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BYTES      = 52;
    localparam int TEX_SIDE       = 64;
    localparam int TEX_BITS       = 6;
    localparam int LINE_PIXELS    = ROW_BYTES * 8;
    localparam int NUM_SCRIPT     = 22;
    localparam int STALL_CYCLES   = 700;
    localparam int DRAIN_CYCLES   = 450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    localparam logic [3:0] SHADE_NIBBLES [18][4] = '{
        '{4'h0, 4'h0, 4'h0, 4'h0}, '{4'h0, 4'h0, 4'h0, 4'h0}, '{4'h8, 4'h0, 4'h0, 4'h0},
        '{4'h8, 4'h0, 4'h2, 4'h0}, '{4'h8, 4'h0, 4'ha, 4'h0}, '{4'ha, 4'h0, 4'ha, 4'h0},
        '{4'ha, 4'h0, 4'ha, 4'h1}, '{4'ha, 4'h4, 4'ha, 4'h1}, '{4'ha, 4'h4, 4'ha, 4'h5},
        '{4'ha, 4'h5, 4'ha, 4'h5}, '{4'hd, 4'h5, 4'ha, 4'h5}, '{4'hd, 4'h5, 4'he, 4'h5},
        '{4'hd, 4'h5, 4'hf, 4'h5}, '{4'hf, 4'h5, 4'hf, 4'h5}, '{4'hf, 4'h5, 4'hf, 4'hd},
        '{4'hf, 4'h7, 4'hf, 4'hd}, '{4'hf, 4'h7, 4'hf, 4'hf}, '{4'hf, 4'hf, 4'hf, 4'hf}
    };

    typedef struct packed {
        logic        last;
        logic [7:0]  data;
        logic [7:0]  mask;
        logic [13:0] addr;
    } t_byte_write;

    typedef enum logic [1:0] {
        OUT_MODEL,
        OUT_NONE,
        OUT_ONE
    } t_out_kind;

    typedef enum logic [1:0] {
        SPAN_ROW_LOCKED,
        SPAN_TRUNCATED,
        SPAN_EMPTY,
        SPAN_FULL
    } t_span_kind;

    typedef struct {
        logic               act;
        dstd_pkg::t_in_item it;
        t_out_kind          kind;
        t_byte_write        w;
    } t_script_row;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [175:0] i_s_tdata  = '0;
    logic         i_s_tuser  = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [31:0]  o_m_tdata;
    logic         o_m_tlast;

    logic [4:0]  shade_mem [TEX_SIDE * TEX_SIDE];
    bit          texel_known [TEX_SIDE * TEX_SIDE];
    t_byte_write pending_writes [$];
    logic [5:0]  fill_row;
    int          src_idle_pct  = 33;
    int          dst_idle_pct  = 72;
    logic        stall_start   = 1'b0;
    int          stall_left    = 0;
    int          quiet_cycles  = 0;
    int          mismatch_count = 0;
    t_script_row script [NUM_SCRIPT];

    dithered_span_texture_draw_top #(
        .ROW_BYTES (ROW_BYTES),
        .TEX_SIDE  (TEX_SIDE)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [11:0] texel_of(input logic [31:0] u, input logic [31:0] v);
        return {v[dstd_pkg::FRAC_BITS +: TEX_BITS], u[dstd_pkg::FRAC_BITS +: TEX_BITS]};
    endfunction

    function automatic t_byte_write byte_write(input int addr, input logic [7:0] mask,
                                               input logic [7:0] data, input logic last);
        t_byte_write w;
        w.addr = 14'(addr);
        w.mask = mask;
        w.data = data & mask;
        w.last = last;
        return w;
    endfunction

    // Update the texture copy and queue the byte writes a beat should cause.
    task automatic model_beat(input logic act, input dstd_pkg::t_in_item it, input bit keep);
        logic [31:0] u;
        logic [31:0] v;
        logic [3:0]  nib;
        logic [7:0]  mask;
        logic [7:0]  data;
        int          xe;
        int          base;
        int          cur;
        if (act == ACT_LOAD) begin
            shade_mem[it.texel_index]   = (it.texel_value > dstd_pkg::MAX_SHADE) ?
                                          dstd_pkg::MAX_SHADE : it.texel_value[4:0];
            texel_known[it.texel_index] = 1'b1;
            return;
        end
        xe = (it.x_end > LINE_PIXELS) ? LINE_PIXELS : it.x_end;
        if (xe <= it.x_start)
            return;
        u    = it.u_frac;
        v    = it.v_frac;
        base = it.row * ROW_BYTES;
        cur  = it.x_start >> 3;
        mask = '0;
        data = '0;
        for (int x = it.x_start; x < xe; x++) begin
            if ((x >> 3) != cur) begin
                if (keep)
                    pending_writes.push_back(byte_write(base + cur, mask, data, 1'b0));
                cur  = x >> 3;
                mask = '0;
                data = '0;
            end
            nib                = SHADE_NIBBLES[shade_mem[texel_of(u, v)]][it.row[1:0]];
            mask[7 - (x & 7)] = 1'b1;
            data[7 - (x & 7)] = nib[3 - (x & 3)];
            u += it.u_step;
            v += it.v_step;
        end
        if (keep)
            pending_writes.push_back(byte_write(base + cur, mask, data, 1'b1));
    endtask

    // Cut a span short before its first fetch of a texel that was never loaded.
    function automatic logic [8:0] known_span_end(input dstd_pkg::t_in_item it);
        logic [31:0] u;
        logic [31:0] v;
        int          xe;
        u  = it.u_frac;
        v  = it.v_frac;
        xe = (it.x_end > LINE_PIXELS) ? LINE_PIXELS : it.x_end;
        for (int x = it.x_start; x < xe; x++) begin
            if (!texel_known[texel_of(u, v)])
                return 9'(x);
            u += it.u_step;
            v += it.v_step;
        end
        return it.x_end;
    endfunction

    function automatic t_script_row load_row(input int idx, input int val);
        t_script_row r;
        r.act            = ACT_LOAD;
        r.it             = '0;
        r.it.texel_index = 12'(idx);
        r.it.texel_value = 8'(val);
        r.kind           = OUT_NONE;
        r.w              = '0;
        return r;
    endfunction

    function automatic t_script_row span_row(input int xs, input int xe, input int row,
                                             input logic [31:0] u, input logic [31:0] v,
                                             input logic [31:0] du, input logic [31:0] dv,
                                             input t_out_kind kind, input int addr,
                                             input logic [7:0] mask, input logic [7:0] data);
        t_script_row r;
        r.act        = ACT_DRAW;
        r.it         = '0;
        r.it.x_start = 9'(xs);
        r.it.x_end   = 9'(xe);
        r.it.row     = 8'(row);
        r.it.u_frac  = u;
        r.it.v_frac  = v;
        r.it.u_step  = du;
        r.it.v_step  = dv;
        r.kind       = kind;
        r.w          = byte_write(addr, mask, data, 1'b1);
        return r;
    endfunction

    function automatic dstd_pkg::t_in_item make_load(input logic [11:0] idx);
        dstd_pkg::t_in_item it;
        it             = 174'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.texel_index = idx;
        it.texel_value = ($urandom_range(1) != 0) ? 8'($urandom_range(17)) : 8'($urandom);
        return it;
    endfunction

    function automatic dstd_pkg::t_in_item make_span(input t_span_kind kind);
        dstd_pkg::t_in_item it;
        int                 xs;
        int                 xe;
        it.texel_index = 12'($urandom);
        it.texel_value = 8'($urandom);
        it.row         = 8'($urandom);
        it.u_frac      = $urandom;
        it.u_step      = $urandom;
        it.v_frac      = $urandom;
        it.v_step      = $urandom;
        it.v_frac[dstd_pkg::FRAC_BITS +: TEX_BITS] = fill_row;
        xs = $urandom_range(415);
        xe = ($urandom_range(4) == 0) ? $urandom_range(511) : xs + $urandom_range(1, 40);
        case (kind)
            SPAN_ROW_LOCKED: begin
                it.v_step[dstd_pkg::FRAC_BITS + TEX_BITS - 1:0] = '0;
            end
            SPAN_TRUNCATED: begin
                if ($urandom_range(1) != 0) begin
                    it.u_step = 32'($urandom_range(16383)) - 32'h2000;
                    it.v_step = 32'($urandom_range(511)) - 32'h100;
                end
            end
            SPAN_EMPTY: begin
                if ($urandom_range(1) != 0) begin
                    xe = $urandom_range(xs);
                end else begin
                    xs = $urandom_range(511, LINE_PIXELS);
                    xe = $urandom_range(511);
                end
            end
            default: begin
                xs = $urandom_range(7);
                xe = $urandom_range(511, LINE_PIXELS - 7);
                it.v_step[dstd_pkg::FRAC_BITS + TEX_BITS - 1:0] = '0;
            end
        endcase
        it.x_start = 9'(xs);
        it.x_end   = 9'((xe > 511) ? 511 : xe);
        if (kind == SPAN_TRUNCATED)
            it.x_end = known_span_end(it);
        return it;
    endfunction

    task automatic send_beat(input logic act, input dstd_pkg::t_in_item it, input bit keep);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, it};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        model_beat(act, it, keep);
    endtask

    task automatic send_random(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 25)
                send_beat(ACT_LOAD, make_load(12'($urandom)), 1'b1);
            else if (pick < 60)
                send_beat(ACT_DRAW, make_span(SPAN_ROW_LOCKED), 1'b1);
            else if (pick < 88)
                send_beat(ACT_DRAW, make_span(SPAN_TRUNCATED), 1'b1);
            else
                send_beat(ACT_DRAW, make_span(SPAN_EMPTY), 1'b1);
        end
    endtask

    task automatic drain_writes();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_write(input string what, input t_byte_write want,
                                input t_byte_write got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: exp addr %0d mask %02h data %02h last %0b, act %0d %02h %02h %0b",
                     what, want.addr, want.mask, want.data, want.last,
                     got.addr, got.mask, got.data, got.last);
    endtask

    task automatic check_write();
        t_byte_write got;
        t_byte_write want;
        got.addr = o_m_tdata[13:0];
        got.mask = o_m_tdata[21:14];
        got.data = o_m_tdata[29:22];
        got.last = o_m_tlast;
        if (pending_writes.size() == 0) begin
            report_write("unexpected write", '0, got);
            return;
        end
        want = pending_writes.pop_front();
        if (got.addr !== want.addr || got.mask !== want.mask ||
            got.data !== want.data || got.last !== want.last)
            report_write("write mismatch", want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_write();
        if (stall_start) begin
            stall_left <= STALL_CYCLES;
            i_m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        script = '{
            load_row(0, 0),
            load_row(1, 17),
            load_row(2, 18),
            load_row(4095, 255),
            load_row(4032, 9),
            load_row(64, 7),
            load_row(65, 12),
            span_row(0, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0, OUT_ONE, 0, 8'h80, 8'h00),
            span_row(0, 8, 3, 32'h1000, 32'h0, 32'h0, 32'h0, OUT_ONE, 156, 8'hff, 8'hff),
            span_row(408, 511, 255, 32'h3f000, 32'h3f000, 32'h0, 32'h0,
                     OUT_ONE, 13311, 8'hff, 8'hff),
            span_row(8, 12, 2, 32'h2000, 32'h0, 32'h0, 32'h0, OUT_ONE, 105, 8'hf0, 8'hf0),
            span_row(10, 10, 4, 32'h0, 32'h0, 32'h0, 32'h0, OUT_NONE, 0, 8'h0, 8'h0),
            span_row(20, 5, 4, 32'h0, 32'h0, 32'h0, 32'h0, OUT_NONE, 0, 8'h0, 8'h0),
            span_row(416, 511, 4, 32'h0, 32'h0, 32'h0, 32'h0, OUT_NONE, 0, 8'h0, 8'h0),
            span_row(511, 0, 4, 32'h0, 32'h0, 32'h0, 32'h0, OUT_NONE, 0, 8'h0, 8'h0),
            span_row(0, 3, 1, 32'hfffff800, 32'hfffff000, 32'h800, 32'h0,
                     OUT_MODEL, 0, 8'h0, 8'h0),
            span_row(100, 103, 2, 32'h7ffff800, 32'hfffff000, 32'h800, 32'h0,
                     OUT_MODEL, 0, 8'h0, 8'h0),
            span_row(5, 8, 0, 32'h0, 32'h800, 32'h0, 32'hfffff800, OUT_MODEL, 0, 8'h0, 8'h0),
            span_row(3, 20, 1, 32'h0, 32'h1000, 32'h0, 32'h0, OUT_MODEL, 0, 8'h0, 8'h0),
            span_row(3, 20, 3, 32'h0, 32'h1000, 32'h0, 32'h0, OUT_MODEL, 0, 8'h0, 8'h0),
            span_row(5, 27, 6, 32'h0, 32'h1000, 32'h7f, 32'h3, OUT_MODEL, 0, 8'h0, 8'h0),
            span_row(0, 416, 254, 32'h3f000, 32'h3f000, 32'h0, 32'h0,
                     OUT_MODEL, 0, 8'h0, 8'h0)
        };
        fill_row = 6'($urandom_range(TEX_SIDE - 1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            send_beat(script[i].act, script[i].it, script[i].kind == OUT_MODEL);
            if (script[i].kind == OUT_ONE)
                pending_writes.push_back(script[i].w);
        end

        // fill one texture row so that random spans locked to it read only loaded texels
        for (int i = 0; i < TEX_SIDE; i++)
            send_beat(ACT_LOAD, make_load({fill_row, 6'(i)}), 1'b1);
        send_random(40);
        drain_writes();

        src_idle_pct = 72;
        dst_idle_pct <= 33;
        send_random(55);
        drain_writes();

        src_idle_pct = 0;
        dst_idle_pct <= 0;
        stall_start  <= 1'b1;
        @(posedge i_clk);
        stall_start  <= 1'b0;
        repeat (6)
            send_beat(ACT_DRAW, make_span(SPAN_FULL), 1'b1);
        send_random(45);
        drain_writes();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dstd_pkg.sv
hdl/dstd_ctrl.sv
hdl/dstd_datapath.sv
hdl/dithered_span_texture_draw_top.sv
tb/dithered_span_texture_draw_top_tb.sv
